/* hdl/ugbp_pkg.sv */
// Package for the uniform-grid broadphase pair finder.
// Holds sizes, payload structs, register indexes and the state encoding.
// No dependencies.
`default_nettype none
package ugbp_pkg;
  localparam int MaxObjects   = 64;
  localparam int GridDim      = 8;
  localparam int CellCapacity = 8;
  localparam int IdW   = $clog2(MaxObjects);
  localparam int DimW  = $clog2(GridDim);
  localparam int CellW = 2 * DimW;
  localparam int SlotW = $clog2(CellCapacity);
  localparam int FillW = SlotW + 1;
  localparam int MemW  = CellW + SlotW;

  localparam logic [2:0] RegOriginX = 3'd0;
  localparam logic [2:0] RegOriginY = 3'd1;
  localparam logic [2:0] RegFarX    = 3'd2;
  localparam logic [2:0] RegFarY    = 3'd3;
  localparam logic [2:0] RegInvCell = 3'd4;
  localparam logic [2:0] RegCols    = 3'd5;
  localparam logic [2:0] RegRows    = 3'd6;

  localparam logic [1:0] StBinned   = 2'd0;
  localparam logic [1:0] StOutside  = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  typedef struct packed {
    logic              frame_start;
    logic [IdW-1:0]    object_id;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
  } obj_in_t;

  typedef struct packed {
    logic           pair_valid;
    logic [IdW-1:0] id_small;
    logic [IdW-1:0] id_large;
    logic [1:0]     status;
    logic           run_last;
  } pair_out_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CLR   = 11'b00000000010,
    S_IDX   = 11'b00000000100,
    S_MULW  = 11'b00000001000,
    S_CHKR  = 11'b00000010000,
    S_CHKD  = 11'b00000100000,
    S_CELLR = 11'b00001000000,
    S_CELLD = 11'b00010000000,
    S_MEMR  = 11'b00100000000,
    S_MEMD  = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_e;
endpackage
`default_nettype wire

/* hdl/uniform_grid_broadphase_pairs_core.sv */
// Top level of the uniform-grid broadphase pair finder; the receiver cannot stall.
// Steps: index computation, an overflow check of each covered cell, then a member scan and append
// per covered cell; an inverted box ends after one check, one outside the grid at once; frame start clears first.
// Throughput: one object at a time; busy stays high until the closing result is strobed.
// Reset clears control state, then busy stays high while the fill counts of all 64 cells clear.
// Member memory is never cleared, since a cell is read only below its fill count.
`default_nettype none
module uniform_grid_broadphase_pairs_core import ugbp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire obj_in_t     obj_i,
  output logic             out_valid_o,
  output pair_out_t        pair_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic signed [31:0] org_x, org_y, far_x, far_y;
  logic [31:0] inv_cell;
  logic [3:0]  cols_r, rows_r;

  ugbp_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .origin_x_o(org_x), .origin_y_o(org_y), .far_x_o(far_x), .far_y_o(far_y),
    .inv_cell_o(inv_cell), .cols_o(cols_r), .rows_o(rows_r)
  );

  state_e state_q, state_d;
  obj_in_t obj_q;
  logic [DimW-1:0] cx0_q, cx1_q, cy0_q, cy1_q, c_q, r_q;
  logic [CellW-1:0] clr_q;
  logic init_clr_q;
  logic [MaxObjects-1:0] seen_q;
  logic [1:0] status_q;
  logic empty_q;
  logic [FillW-1:0] fill_q;
  logic [SlotW-1:0] k_q;
  logic [IdW:0] n_q;
  logic [1:0] ax_q;
  logic [63:0] prod_q;
  logic neg_q;

  // Memories: fill counts and cell members.
  logic [FillW-1:0] fill_mem [GridDim*GridDim];
  logic [IdW-1:0]   mem_mem  [GridDim*GridDim*CellCapacity];
  logic [FillW-1:0] fill_rd;
  logic [IdW-1:0]   mem_rd;
  logic             fill_we, mem_we;
  logic [CellW-1:0] fill_waddr;
  logic [FillW-1:0] fill_wdata;
  logic [FillW-1:0] fill_cur;
  logic [CellW-1:0] cell_addr;
  logic [MemW-1:0]  mem_raddr, mem_waddr;

  assign cell_addr = {r_q, c_q};

  // The fill of the current cell comes straight from memory in the cell step.
  assign fill_cur = (state_q == S_CELLD) ? fill_rd : fill_q;

  always_ff @(posedge clk_i) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd <= fill_mem[cell_addr];
  end
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_mem[mem_waddr] <= obj_q.object_id;
    mem_rd <= mem_mem[mem_raddr];
  end
  assign mem_raddr = {cell_addr, k_q};
  assign mem_waddr = {cell_addr, fill_cur[SlotW-1:0]};

  // Corner-inside test and effective grid size.
  function automatic logic in_grid(input logic signed [31:0] x, input logic signed [31:0] y,
                                   input logic signed [31:0] ox, input logic signed [31:0] oy,
                                   input logic signed [31:0] fx, input logic signed [31:0] fy);
    in_grid = x >= ox && x <= fx && y >= oy && y <= fy;
  endfunction
  function automatic logic [DimW:0] used_dim(input logic [3:0] v);
    if (v == 4'd0) used_dim = (DimW+1)'(1);
    else if (32'(v) > GridDim) used_dim = (DimW+1)'(GridDim);
    else used_dim = (DimW+1)'(v);
  endfunction

  logic any_in;
  assign any_in = in_grid(obj_q.box_min_x, obj_q.box_min_y, org_x, org_y, far_x, far_y) ||
                  in_grid(obj_q.box_max_x, obj_q.box_min_y, org_x, org_y, far_x, far_y) ||
                  in_grid(obj_q.box_max_x, obj_q.box_max_y, org_x, org_y, far_x, far_y) ||
                  in_grid(obj_q.box_min_x, obj_q.box_max_y, org_x, org_y, far_x, far_y);

  // Index computation, one coordinate at a time over S_IDX and S_MULW: subtract, multiply, clamp.
  logic signed [31:0] coord, org;
  logic signed [32:0] diff;
  logic [DimW:0] lim;
  logic [DimW-1:0] idx_val;
  always_comb begin
    case (ax_q)
      2'd0: begin coord = obj_q.box_min_x; org = org_x; lim = used_dim(cols_r); end
      2'd1: begin coord = obj_q.box_max_x; org = org_x; lim = used_dim(cols_r); end
      2'd2: begin coord = obj_q.box_min_y; org = org_y; lim = used_dim(rows_r); end
      default: begin coord = obj_q.box_max_y; org = org_y; lim = used_dim(rows_r); end
    endcase
    diff = 33'(coord) - 33'(org);
    if (neg_q) idx_val = '0;
    else if (prod_q[63:32] > 32'(lim - 1'b1)) idx_val = DimW'(lim - 1'b1);
    else idx_val = prod_q[DimW+31:32];
  end

  logic out_v_q;
  pair_out_t out_q;
  logic [IdW-1:0] m;
  logic cell_last;
  assign m = mem_rd;
  assign cell_last = (c_q == cx1_q) && (r_q == cy1_q);
  assign busy = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    fill_we = 1'b0;
    fill_waddr = cell_addr;
    fill_wdata = fill_cur + 1'b1;
    mem_we = 1'b0;
    case (state_q)
      S_IDLE:  if (start) state_d = obj_i.frame_start ? S_CLR : S_IDX;
      S_CLR: begin
        fill_we = 1'b1; fill_waddr = clr_q; fill_wdata = '0;
        if (clr_q == CellW'(GridDim*GridDim-1)) state_d = init_clr_q ? S_IDLE : S_IDX;
      end
      S_IDX:   state_d = any_in ? S_MULW : S_DONE;
      S_MULW:  state_d = (ax_q == 2'd3) ? S_CHKR : S_IDX;
      S_CHKR:  state_d = S_CHKD;
      S_CHKD:  state_d = empty_q ? S_DONE : (cell_last ? S_CELLR : S_CHKR);
      S_CELLR: state_d = S_CELLD;
      S_CELLD: state_d = (fill_rd == '0) ? S_CELLR : S_MEMR;
      S_MEMR:  state_d = S_MEMD;
      S_MEMD:  state_d = S_MEMR;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // Append, if the cell has room, once the cell's members have been scanned.
    if ((state_q == S_CELLD && fill_rd == '0) ||
        (state_q == S_MEMD && 32'(k_q) + 1 >= 32'(fill_q))) begin
      if (32'(fill_cur) < CellCapacity) begin
        fill_we = 1'b1;
        mem_we = 1'b1;
      end
      if (cell_last) state_d = S_DONE;
      else state_d = S_CELLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; out_v_q <= 1'b0; clr_q <= '0; ax_q <= '0; init_clr_q <= 1'b1;
      seen_q <= '0; n_q <= '0; status_q <= StBinned; empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (start) begin
          obj_q <= obj_i; clr_q <= '0; ax_q <= '0; seen_q <= '0; n_q <= '0;
          status_q <= StBinned;
        end
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CellW'(GridDim*GridDim-1)) init_clr_q <= 1'b0;
        end
        S_IDX: begin
          neg_q <= diff[32];
          prod_q <= 64'(diff[31:0]) * 64'(inv_cell);
          if (!any_in) status_q <= StOutside;
        end
        S_MULW: begin
          case (ax_q)
            2'd0: cx0_q <= idx_val;
            2'd1: cx1_q <= idx_val;
            2'd2: cy0_q <= idx_val;
            default: cy1_q <= idx_val;
          endcase
          ax_q <= ax_q + 1'b1;
          if (ax_q == 2'd3) begin
            c_q <= cx0_q; r_q <= cy0_q;
            empty_q <= (cx1_q < cx0_q) || (idx_val < cy0_q);
          end
        end
        S_CHKD: begin
          if (!empty_q && 32'(fill_rd) >= CellCapacity) status_q <= StOverflow;
          if (cell_last || empty_q) begin c_q <= cx0_q; r_q <= cy0_q; end
          else if (c_q == cx1_q) begin c_q <= cx0_q; r_q <= r_q + 1'b1; end
          else c_q <= c_q + 1'b1;
        end
        S_CELLD: begin fill_q <= fill_rd; k_q <= '0; end
        S_MEMD: begin
          if (m != obj_q.object_id && !seen_q[m] && 32'(n_q) < MaxObjects - 1) begin
            seen_q[m] <= 1'b1;
            n_q <= n_q + 1'b1;
            out_v_q <= 1'b1;
            out_q.pair_valid <= 1'b1;
            out_q.id_small <= (m < obj_q.object_id) ? m : obj_q.object_id;
            out_q.id_large <= (m < obj_q.object_id) ? obj_q.object_id : m;
            out_q.status <= status_q;
            out_q.run_last <= 1'b0;
          end
          k_q <= k_q + 1'b1;
        end
        S_DONE: begin
          out_v_q <= 1'b1;
          out_q <= '{pair_valid: 1'b0, id_small: '0, id_large: '0,
                     status: status_q, run_last: 1'b1};
        end
        default: ;
      endcase
      // Advance the cell pointer after an append.
      if (state_d == S_CELLR && (state_q == S_CELLD || state_q == S_MEMD)) begin
        if (c_q == cx1_q) begin c_q <= cx0_q; r_q <= r_q + 1'b1; end
        else c_q <= c_q + 1'b1;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign pair_o = out_q;

  // A closing result only leaves when returning to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.run_last |-> state_q == S_IDLE) else $error("closing result mistimed");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |=> state_q != S_IDLE || $past(state_q) == S_DONE ||
                          $past(state_q) == S_CLR)
    else $error("left busy without done");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.pair_valid |-> out_q.id_small < out_q.id_large)
    else $error("pair not ordered");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule
`default_nettype wire

/* hdl/ugbp_cfg_regs.sv */
// APB-style configuration register file of the broadphase block.
// Depends on ugbp_pkg.
`default_nettype none
module ugbp_cfg_regs import ugbp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic signed [31:0] origin_x_o,
  output logic signed [31:0] origin_y_o,
  output logic signed [31:0] far_x_o,
  output logic signed [31:0] far_y_o,
  output logic [31:0]      inv_cell_o,
  output logic [3:0]       cols_o,
  output logic [3:0]       rows_o
);
  logic [31:0] ox_q, oy_q, fx_q, fy_q, inv_q;
  logic [3:0]  cols_q, rows_q;
  logic        wr;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  // Register writes on the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q <= '0; oy_q <= '0; fx_q <= 32'd6553600; fy_q <= 32'd6553600;
      inv_q <= 32'd655; cols_q <= 4'd1; rows_q <= 4'd1;
    end else if (wr) begin
      case (idx)
        RegOriginX: ox_q <= pwdata;
        RegOriginY: oy_q <= pwdata;
        RegFarX:    fx_q <= pwdata;
        RegFarY:    fy_q <= pwdata;
        RegInvCell: inv_q <= pwdata;
        RegCols:    cols_q <= pwdata[3:0];
        RegRows:    rows_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      RegOriginX: prdata = ox_q;
      RegOriginY: prdata = oy_q;
      RegFarX:    prdata = fx_q;
      RegFarY:    prdata = fy_q;
      RegInvCell: prdata = inv_q;
      RegCols:    prdata = {28'd0, cols_q};
      RegRows:    prdata = {28'd0, rows_q};
      default:    prdata = '0;
    endcase
  end

  assign origin_x_o = ox_q;
  assign origin_y_o = oy_q;
  assign far_x_o    = fx_q;
  assign far_y_o    = fy_q;
  assign inv_cell_o = inv_q;
  assign cols_o     = cols_q;
  assign rows_o     = rows_q;
endmodule
`default_nettype wire
